@@ rtl/single_source_shortest_path_unit_assert.svh @@
// Assertion macros shared by the shortest path unit RTL.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_UNIT_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SSSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sssp assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SSSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sssp assertion failed");

`endif

@@ rtl/sssp_pkg.sv @@
// Shared types and constants of the shortest path unit.
package sssp_pkg;

  // fixed port widths
  localparam int unsigned VTX_W = 4;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned CFG_W = 5;

  // vertex_count value after reset
  localparam logic [CFG_W-1:0] VCOUNT_RESET = 5'd16;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_RUN   = 2'd2
  } op_e;

  // modes of the shared add/compare unit
  typedef enum logic [1:0] {
    ALU_INIT   = 2'd0,
    ALU_SELECT = 2'd1,
    ALU_RELAX  = 2'd2
  } alu_op_e;

endpackage

@@ rtl/sssp_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module sssp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sssp_alu.sv @@
// Shared saturating adder and comparator used by every sweep of a run.
module sssp_alu #(
  parameter int unsigned COST_BITS = 16,
  parameter int unsigned DIST_BITS = 20
) (
  input  sssp_pkg::alu_op_e     op_i,
  input  logic [DIST_BITS-1:0]  least_i,
  input  logic [COST_BITS-1:0]  cost_i,
  input  logic [DIST_BITS-1:0]  dist_i,
  output logic [DIST_BITS-1:0]  value_o,
  output logic                  take_o
);

  import sssp_pkg::*;

  localparam int unsigned SUM_W = ((COST_BITS > DIST_BITS) ? COST_BITS : DIST_BITS) + 1;

  logic [SUM_W-1:0]     add_a;
  logic [SUM_W-1:0]     sum_w;
  logic [SUM_W-1:0]     dist_all_w;
  logic [DIST_BITS-1:0] sum_sat;
  logic [DIST_BITS-1:0] cmp_a;
  logic [DIST_BITS-1:0] cmp_b;
  logic                 cost_none;
  logic                 lt;

  assign cost_none  = (cost_i == {COST_BITS{1'b1}});
  assign dist_all_w = SUM_W'({DIST_BITS{1'b1}});

  // one adder: init mode adds nothing so the cost saturates into distance range
  assign add_a   = (op_i == ALU_INIT) ? '0 : SUM_W'(least_i);
  assign sum_w   = add_a + SUM_W'(cost_i);
  assign sum_sat = (sum_w > dist_all_w) ? {DIST_BITS{1'b1}} : DIST_BITS'(sum_w);

  // one comparator
  assign cmp_a = (op_i == ALU_SELECT) ? dist_i  : sum_sat;
  assign cmp_b = (op_i == ALU_SELECT) ? least_i : dist_i;
  assign lt    = (cmp_a < cmp_b);

  always_comb begin
    case (op_i)
      ALU_INIT: begin
        value_o = cost_none ? {DIST_BITS{1'b1}} : sum_sat;
        take_o  = 1'b1;
      end
      ALU_SELECT: begin
        value_o = dist_i;
        take_o  = lt;
      end
      ALU_RELAX: begin
        value_o = sum_sat;
        take_o  = lt && !cost_none;
      end
      default: begin
        value_o = sum_sat;
        take_o  = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/single_source_shortest_path_unit.sv @@
// Top level: dense-matrix Dijkstra unit with edge store, sequencer and result port.
//
//  channel  | handshake               | beat contents
//  ---------+-------------------------+------------------------------------------------
//  input    | in_valid_i / in_stall_o | operation, from/to vertex, edge cost, source
//  output   | out_valid_o/out_stall_i | vertex, distance, last
//  config   | cfg_we_i                | vertex_count (cfg_wdata_i)
//
// Clear drops all row valid bits. An edge write into a row written since the last clear
// goes to the RAM directly; a first write fills its row through the RAM write port.
// Run with n vertices: init sweep, then per round a select sweep, a pick state and a
// relax sweep on the shared add/compare unit, then a read and a load state per beat.
// Output stalls only extend the result phase.
// Reset needs no clearing pass: per-row valid bits make unwritten rows read as cleared.
`include "single_source_shortest_path_unit_assert.svh"

module single_source_shortest_path_unit #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned COST_BITS    = 16,
  parameter int unsigned DIST_BITS    = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [sssp_pkg::CFG_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sssp_pkg::OP_W-1:0]  operation_i,
  input  logic [sssp_pkg::VTX_W-1:0] from_vertex_i,
  input  logic [sssp_pkg::VTX_W-1:0] to_vertex_i,
  input  logic [COST_BITS-1:0]       edge_cost_i,
  input  logic [sssp_pkg::VTX_W-1:0] source_vertex_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sssp_pkg::VTX_W-1:0] vertex_o,
  output logic [DIST_BITS-1:0]       distance_o,
  output logic                       last_o
);

  import sssp_pkg::*;

  localparam int unsigned IW        = $clog2(MAX_VERTICES);
  localparam int unsigned CW        = $clog2(MAX_VERTICES + 1);
  localparam int unsigned ADJ_DEPTH = 1 << (2 * IW);
  localparam int unsigned DST_DEPTH = 1 << IW;

  localparam logic [COST_BITS-1:0] COST_ALL = {COST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] DIST_ALL = {DIST_BITS{1'b1}};

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FILL   = 8'b0000_0010,
    ST_INIT   = 8'b0000_0100,
    ST_SEL    = 8'b0000_1000,
    ST_PICK   = 8'b0001_0000,
    ST_RELAX  = 8'b0010_0000,
    ST_OUT_RD = 8'b0100_0000,
    ST_OUT_LD = 8'b1000_0000
  } state_e;

  // control registers
  state_e              state_q, state_d;
  logic [CFG_W-1:0]    vcount_q, vcount_d;
  logic [CW-1:0]       n_q, n_d;
  logic                src_ok_q, src_ok_d;
  logic [CW-1:0]       round_q, round_d;
  logic [IW-1:0]       j_q, j_d;
  logic                issue_q, issue_d;
  logic                vd_q, vd_d;
  logic [IW-1:0]       jd_q, jd_d;
  logic                found_q, found_d;
  logic [MAX_VERTICES-1:0] sel_q, sel_d;
  logic [MAX_VERTICES-1:0] row_valid_q, row_valid_d;
  logic                out_valid_q, out_valid_d;

  // payload registers
  logic [IW-1:0]        src_q, src_d;
  logic [IW-1:0]        row_q, row_d;
  logic [IW-1:0]        to_q, to_d;
  logic [IW-1:0]        col_q, col_d;
  logic [COST_BITS-1:0] cost_q, cost_d;
  logic [DIST_BITS-1:0] least_q, least_d;
  logic [IW-1:0]        pick_q, pick_d;
  logic [VTX_W-1:0]     vertex_q, vertex_d;
  logic [DIST_BITS-1:0] distance_q, distance_d;
  logic                 last_q, last_d;

  // datapath signals
  logic                 in_fire;
  logic                 out_free;
  logic [CW-1:0]        n_run;
  logic                 src_in_range;
  logic                 edge_in_range;
  logic [IW-1:0]        from_idx;
  logic [IW-1:0]        to_idx;
  logic [IW-1:0]        src_idx;
  logic                 jd_last;
  logic                 j_last;
  logic [IW-1:0]        rowsel;

  logic                 adj_we;
  logic [2*IW-1:0]      adj_waddr;
  logic [COST_BITS-1:0] adj_wdata;
  logic [COST_BITS-1:0] adj_rdata;
  logic [COST_BITS-1:0] adj_cost;

  logic                 dst_we;
  logic [DIST_BITS-1:0] dst_wdata;
  logic [DIST_BITS-1:0] dst_rdata;

  alu_op_e              alu_op;
  logic [DIST_BITS-1:0] alu_value;
  logic                 alu_take;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // field decode
  assign from_idx      = IW'(from_vertex_i);
  assign to_idx        = IW'(to_vertex_i);
  assign src_idx       = IW'(source_vertex_i);
  assign edge_in_range = (32'(from_vertex_i) < MAX_VERTICES) && (32'(to_vertex_i) < MAX_VERTICES);

  // vertex count in use: zero reads as one, large values clamp
  always_comb begin
    if (vcount_q == '0) begin
      n_run = CW'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      n_run = CW'(MAX_VERTICES);
    end else begin
      n_run = CW'(vcount_q);
    end
  end
  assign src_in_range = (32'(source_vertex_i) < 32'(n_run));

  assign jd_last = (CW'(jd_q) == n_q - CW'(1));
  assign j_last  = (CW'(j_q) == n_q - CW'(1));

  // adjacency row read by the current sweep
  assign rowsel = (state_q == ST_INIT) ? src_q : pick_q;

  // unwritten rows read as cleared: zero on the diagonal, no edge elsewhere
  always_comb begin
    if (row_valid_q[rowsel]) begin
      adj_cost = adj_rdata;
    end else if (jd_q == rowsel) begin
      adj_cost = '0;
    end else begin
      adj_cost = COST_ALL;
    end
  end

  // adjacency write port: direct edge write or row fill
  always_comb begin
    if (state_q == ST_FILL) begin
      adj_we    = 1'b1;
      adj_waddr = {row_q, col_q};
      if (col_q == to_q) begin
        adj_wdata = cost_q;
      end else if (col_q == row_q) begin
        adj_wdata = '0;
      end else begin
        adj_wdata = COST_ALL;
      end
    end else begin
      adj_we    = in_fire && (operation_i == OP_WRITE) && edge_in_range && row_valid_q[from_idx];
      adj_waddr = {from_idx, to_idx};
      adj_wdata = edge_cost_i;
    end
  end

  // shared unit mode follows the sweep
  always_comb begin
    case (state_q)
      ST_INIT: alu_op = ALU_INIT;
      ST_SEL:  alu_op = ALU_SELECT;
      default: alu_op = ALU_RELAX;
    endcase
  end

  // distance store writes: init sweep fills, relax sweep improves
  always_comb begin
    dst_we    = 1'b0;
    dst_wdata = alu_value;
    if (vd_q && (state_q == ST_INIT)) begin
      dst_we = 1'b1;
      if (!src_ok_q) begin
        dst_wdata = DIST_ALL;
      end else if (jd_q == src_q) begin
        dst_wdata = '0;
      end
    end else if (vd_q && (state_q == ST_RELAX)) begin
      dst_we = !sel_q[jd_q] && alu_take;
    end
  end

  sssp_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (ADJ_DEPTH)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i ({rowsel, j_q}),
    .rdata_o (adj_rdata)
  );

  sssp_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (DST_DEPTH)
  ) u_dst_ram (
    .clk_i   (clk_i),
    .we_i    (dst_we),
    .waddr_i (jd_q),
    .wdata_i (dst_wdata),
    .raddr_i (j_q),
    .rdata_o (dst_rdata)
  );

  sssp_alu #(
    .COST_BITS (COST_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_alu (
    .op_i    (alu_op),
    .least_i (least_q),
    .cost_i  (adj_cost),
    .dist_i  (dst_rdata),
    .value_o (alu_value),
    .take_o  (alu_take)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    vcount_d    = vcount_q;
    n_d         = n_q;
    src_ok_d    = src_ok_q;
    round_d     = round_q;
    j_d         = j_q;
    issue_d     = issue_q;
    vd_d        = 1'b0;
    jd_d        = j_q;
    found_d     = found_q;
    sel_d       = sel_q;
    row_valid_d = row_valid_q;
    src_d       = src_q;
    row_d       = row_q;
    to_d        = to_q;
    col_d       = col_q;
    cost_d      = cost_q;
    least_d     = least_q;
    pick_d      = pick_q;
    vertex_d    = vertex_q;
    distance_d  = distance_q;
    last_d      = last_q;
    out_valid_d = (out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q;

    if (cfg_we_i) begin
      vcount_d = cfg_wdata_i;
    end

    // sweep issue: one address per cycle, data in the next cycle
    if (issue_q && (state_q == ST_INIT || state_q == ST_SEL || state_q == ST_RELAX)) begin
      vd_d    = 1'b1;
      j_d     = j_q + IW'(1);
      issue_d = !j_last;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (operation_i)
            OP_CLEAR: begin
              row_valid_d = '0;
            end
            OP_WRITE: begin
              if (edge_in_range && !row_valid_q[from_idx]) begin
                row_d   = from_idx;
                to_d    = to_idx;
                cost_d  = edge_cost_i;
                col_d   = '0;
                state_d = ST_FILL;
              end
            end
            OP_RUN: begin
              n_d      = n_run;
              src_ok_d = src_in_range;
              src_d    = src_idx;
              sel_d    = src_in_range ? (MAX_VERTICES'(1) << src_idx) : '0;
              j_d      = '0;
              issue_d  = 1'b1;
              state_d  = ST_INIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        col_d = col_q + IW'(1);
        if (col_q == IW'(MAX_VERTICES - 1)) begin
          row_valid_d[row_q] = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_INIT: begin
        if (vd_q && jd_last) begin
          j_d     = '0;
          issue_d = 1'b1;
          if (!src_ok_q || n_q == CW'(1)) begin
            state_d = ST_OUT_RD;
          end else begin
            round_d = CW'(1);
            least_d = DIST_ALL;
            found_d = 1'b0;
            state_d = ST_SEL;
          end
        end
      end
      ST_SEL: begin
        // running minimum over unselected vertices, lowest index wins ties
        if (vd_q && !sel_q[jd_q] && alu_take) begin
          least_d = alu_value;
          pick_d  = jd_q;
          found_d = 1'b1;
        end
        if (vd_q && jd_last) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        j_d     = '0;
        issue_d = 1'b1;
        if (found_q) begin
          sel_d[pick_q] = 1'b1;
          state_d       = ST_RELAX;
        end else begin
          state_d = ST_OUT_RD;
        end
      end
      ST_RELAX: begin
        if (vd_q && jd_last) begin
          j_d     = '0;
          issue_d = 1'b1;
          round_d = round_q + CW'(1);
          if (round_q + CW'(1) == n_q) begin
            state_d = ST_OUT_RD;
          end else begin
            least_d = DIST_ALL;
            found_d = 1'b0;
            state_d = ST_SEL;
          end
        end
      end
      ST_OUT_RD: begin
        // distance read is issued once the output register frees up
        if (out_free) begin
          state_d = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        out_valid_d = 1'b1;
        vertex_d    = VTX_W'(j_q);
        distance_d  = dst_rdata;
        last_d      = j_last;
        if (j_last) begin
          state_d = ST_IDLE;
        end else begin
          j_d     = j_q + IW'(1);
          state_d = ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= VCOUNT_RESET;
      n_q         <= CW'(1);
      src_ok_q    <= 1'b0;
      round_q     <= '0;
      j_q         <= '0;
      issue_q     <= 1'b0;
      vd_q        <= 1'b0;
      jd_q        <= '0;
      found_q     <= 1'b0;
      sel_q       <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      n_q         <= n_d;
      src_ok_q    <= src_ok_d;
      round_q     <= round_d;
      j_q         <= j_d;
      issue_q     <= issue_d;
      vd_q        <= vd_d;
      jd_q        <= jd_d;
      found_q     <= found_d;
      sel_q       <= sel_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    row_q      <= row_d;
    to_q       <= to_d;
    col_q      <= col_d;
    cost_q     <= cost_d;
    least_q    <= least_d;
    pick_q     <= pick_d;
    vertex_q   <= vertex_d;
    distance_q <= distance_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = vertex_q;
  assign distance_o  = distance_q;
  assign last_o      = last_q;

  // checks
  `SSSP_ASSERT_NEXT(a_load_shows_beat, state_q == ST_OUT_LD, out_valid_o)
  `SSSP_ASSERT_NOW(a_relax_pick_selected, state_q == ST_RELAX, sel_q[pick_q])
  `SSSP_ASSERT_NOW(a_sel_within_count, 1'b1, $countones(sel_q) <= 32'(n_q))
  `SSSP_ASSERT_NOW(a_dist_write_phase, dst_we, state_q == ST_INIT || state_q == ST_RELAX)
  `SSSP_ASSERT_NOW(a_fill_row_unwritten, state_q == ST_FILL, !row_valid_q[row_q])

endmodule

@@ tb/sssp_distance_checker.sv @@
`timescale 1ns / 100ps
// Checker for the shortest path unit: tracks the edge store, predicts distance beats, compares.
module sssp_distance_checker #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned COST_BITS    = 16,
  parameter int unsigned DIST_BITS    = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sssp_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [sssp_pkg::OP_W-1:0]  operation_i,
  input  logic [sssp_pkg::VTX_W-1:0] from_vertex_i,
  input  logic [sssp_pkg::VTX_W-1:0] to_vertex_i,
  input  logic [COST_BITS-1:0]       edge_cost_i,
  input  logic [sssp_pkg::VTX_W-1:0] source_vertex_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [sssp_pkg::VTX_W-1:0] vertex_i,
  input  logic [DIST_BITS-1:0]       distance_i,
  input  logic                       last_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import sssp_pkg::*;

  localparam logic [COST_BITS-1:0] NO_EDGE     = {COST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] UNREACHABLE = {DIST_BITS{1'b1}};

  typedef struct packed {
    logic [VTX_W-1:0]     vertex;
    logic [DIST_BITS-1:0] distance;
    logic                 last;
  } dist_beat_t;

  logic [COST_BITS-1:0] edge_cost_mem [MAX_VERTICES][MAX_VERTICES];
  logic [CFG_W-1:0]     vcount;
  dist_beat_t           dist_due_q [$];
  int                   fails;

  // clear: zero diagonal, no edge elsewhere
  function automatic void clear_edges();
    for (int r = 0; r < MAX_VERTICES; r++)
      for (int c = 0; c < MAX_VERTICES; c++)
        edge_cost_mem[r][c] = (r == c) ? '0 : NO_EDGE;
  endfunction

  function automatic logic [DIST_BITS-1:0] cost_to_dist(input logic [COST_BITS-1:0] cost);
    return (cost == NO_EDGE) ? UNREACHABLE : DIST_BITS'(cost);
  endfunction

  // Dijkstra over the first n vertices; queues one beat per vertex
  function automatic void predict_distances(input logic [VTX_W-1:0] src);
    logic [DIST_BITS-1:0] best_dist [MAX_VERTICES];
    logic [DIST_BITS-1:0] least;
    logic [DIST_BITS:0]   sum;
    bit                   done [MAX_VERTICES];
    bit                   found;
    int unsigned          n, pick;
    dist_beat_t           beat;
    n = (vcount == 0) ? 1 : (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
    for (int unsigned i = 0; i < MAX_VERTICES; i++) begin
      best_dist[i] = UNREACHABLE;
      done[i]      = 1'b0;
    end
    // source beyond the vertex count leaves everything unreachable
    if (src < n) begin
      for (int unsigned i = 0; i < n; i++)
        best_dist[i] = cost_to_dist(edge_cost_mem[src][i]);
      best_dist[src] = '0;
      done[src]      = 1'b1;
      found = 1'b1;
      for (int unsigned rnd = 1; rnd < n && found; rnd++) begin
        // least unselected distance, lowest index on a tie
        least = UNREACHABLE;
        found = 1'b0;
        pick  = 0;
        for (int unsigned j = 0; j < n; j++) begin
          if (!done[j] && best_dist[j] < least) begin
            least = best_dist[j];
            pick  = j;
            found = 1'b1;
          end
        end
        if (found) begin
          done[pick] = 1'b1;
          // relax with saturating sums
          for (int unsigned j = 0; j < n; j++) begin
            if (!done[j] && edge_cost_mem[pick][j] != NO_EDGE) begin
              sum = least + edge_cost_mem[pick][j];
              if (sum > UNREACHABLE) sum = UNREACHABLE;
              if (sum < best_dist[j]) best_dist[j] = sum[DIST_BITS-1:0];
            end
          end
        end
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      beat.vertex   = VTX_W'(i);
      beat.distance = best_dist[i];
      beat.last     = (i == n - 1);
      dist_due_q.push_back(beat);
    end
  endfunction

  function automatic void check_distance_beat();
    dist_beat_t want;
    if (dist_due_q.size() == 0) begin
      fails++;
      $display("%0t: unexpected beat: vertex %0d distance %0d last %0b",
               $time, vertex_i, distance_i, last_i);
    end else begin
      want = dist_due_q.pop_front();
      if ({vertex_i, distance_i, last_i} !== want) begin
        fails++;
        $display("%0t: expected vertex %0d dist %0d last %0b, got %0d %0d %0b",
                 $time, want.vertex, want.distance, want.last, vertex_i, distance_i, last_i);
      end
    end
  endfunction

  // watch config, input and output beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_edges();
      vcount = VCOUNT_RESET;
      dist_due_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) vcount = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        case (operation_i)
          OP_CLEAR: clear_edges();
          OP_WRITE: edge_cost_mem[from_vertex_i][to_vertex_i] = edge_cost_i;
          OP_RUN:   predict_distances(source_vertex_i);
          default:  ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_distance_beat();
    end
    fail_count_o <= fails;
    pending_o    <= dist_due_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the shortest path unit testbench: clock, reset, stimulus, receiver and verdict.
module tb_top;
  import sssp_pkg::*;

  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned COST_BITS    = 16;
  localparam int unsigned DIST_BITS    = 20;

  localparam logic [OP_W-1:0]      OP_SPARE = 2'd3;  // unused code, ignored by the block
  localparam logic [COST_BITS-1:0] NO_EDGE  = {COST_BITS{1'b1}};
  localparam logic [COST_BITS-1:0] TOP_COST = NO_EDGE - COST_BITS'(1);

  localparam int SETTLE_CYCLES  = 2 * MAX_VERTICES;  // covers a row fill on a first write
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 23;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i     = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      operation_i     = '0;
  logic [VTX_W-1:0]     from_vertex_i   = '0;
  logic [VTX_W-1:0]     to_vertex_i     = '0;
  logic [COST_BITS-1:0] edge_cost_i     = '0;
  logic [VTX_W-1:0]     source_vertex_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [VTX_W-1:0]     vertex_o;
  logic [DIST_BITS-1:0] distance_o;
  logic                 last_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit hold_pending = 1'b0;
  bit no_gaps = 1'b0;

  int unsigned phase_vcount [PHASES] = '{16, 4, 1, 16, 2, 9, 31, 16, 6, 16};

  wire beat_seen = (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i);

  single_source_shortest_path_unit #(
    .MAX_VERTICES(MAX_VERTICES),
    .COST_BITS   (COST_BITS),
    .DIST_BITS   (DIST_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .from_vertex_i  (from_vertex_i),
    .to_vertex_i    (to_vertex_i),
    .edge_cost_i    (edge_cost_i),
    .source_vertex_i(source_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_o       (vertex_o),
    .distance_o     (distance_o),
    .last_o         (last_o)
  );

  sssp_distance_checker #(
    .MAX_VERTICES(MAX_VERTICES),
    .COST_BITS   (COST_BITS),
    .DIST_BITS   (DIST_BITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .operation_i    (operation_i),
    .from_vertex_i  (from_vertex_i),
    .to_vertex_i    (to_vertex_i),
    .edge_cost_i    (edge_cost_i),
    .source_vertex_i(source_vertex_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_i       (vertex_o),
    .distance_i     (distance_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one beat, hold it until accepted
  task automatic offer_item(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] from_v,
                            input logic [VTX_W-1:0] to_v, input logic [COST_BITS-1:0] cost,
                            input logic [VTX_W-1:0] src);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    from_vertex_i   <= from_v;
    to_vertex_i     <= to_v;
    edge_cost_i     <= cost;
    source_vertex_i <= src;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_edge(input logic [VTX_W-1:0] from_v, input logic [VTX_W-1:0] to_v,
                            input logic [COST_BITS-1:0] cost);
    offer_item(OP_WRITE, from_v, to_v, cost, VTX_W'($urandom));
  endtask

  task automatic run_from(input logic [VTX_W-1:0] src);
    offer_item(OP_RUN, VTX_W'($urandom), VTX_W'($urandom), COST_BITS'($urandom), src);
  endtask

  // drain all expected beats, then let a pending row fill finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one random item, mostly edges and runs inside the vertices in use
  task automatic random_item(input int unsigned n_eff);
    int unsigned      pick;
    logic [VTX_W-1:0] from_v, to_v, src;
    logic [COST_BITS-1:0] cost;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      offer_item(OP_CLEAR, VTX_W'($urandom), VTX_W'($urandom), COST_BITS'($urandom),
                 VTX_W'($urandom));
    end else if (pick < 5) begin
      offer_item(OP_SPARE, VTX_W'($urandom), VTX_W'($urandom), COST_BITS'($urandom),
                 VTX_W'($urandom));
    end else if (pick < 20) begin
      src = VTX_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, n_eff - 1));
      run_from(src);
    end else begin
      from_v = VTX_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, n_eff - 1));
      to_v   = VTX_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, n_eff - 1));
      case ($urandom_range(0, 9))
        0:       cost = '0;
        1:       cost = NO_EDGE;
        2:       cost = COST_BITS'($urandom_range(1000, TOP_COST));
        3:       cost = COST_BITS'($urandom);
        default: cost = COST_BITS'($urandom_range(1, 60));
      endcase
      write_edge(from_v, to_v, cost);
    end
  endtask

  // receiver: random stalls, quiet stretches, and one long hold on request
  initial begin
    int stall_len;
    @(posedge rst_ni);
    forever begin
      if (hold_pending) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_pending = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        stall_len = pick_gap();
        if (stall_len != 0) begin
          out_stall_i <= 1'b1;
          repeat (stall_len) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    wait (rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      idle_cycles = beat_seen ? 0 : idle_cycles + 1;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned n_eff;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // graph straight from reset
    run_from(4'd0);
    run_from(4'd15);
    // zero cost, longest costs, tie between 3 and 4, back edge, diagonal
    write_edge(4'd0, 4'd1, '0);
    write_edge(4'd1, 4'd2, TOP_COST);
    write_edge(4'd2, 4'd15, TOP_COST);
    write_edge(4'd0, 4'd3, 16'd7);
    write_edge(4'd0, 4'd4, 16'd7);
    write_edge(4'd3, 4'd5, 16'd2);
    write_edge(4'd4, 4'd5, 16'd1);
    write_edge(4'd15, 4'd0, 16'd1);
    write_edge(4'd5, 4'd5, 16'd9);
    run_from(4'd0);
    run_from(4'd5);
    // edge removed by writing no-edge, unused operation
    write_edge(4'd1, 4'd2, NO_EDGE);
    offer_item(OP_SPARE, 4'd15, 4'd15, NO_EDGE, 4'd15);
    run_from(4'd0);
    run_from(4'd15);
    offer_item(OP_CLEAR, 4'd15, 4'd15, NO_EDGE, 4'd15);
    run_from(4'd15);
    // vertex count zero acts as one; source past the count
    set_vertex_count(5'd0);
    run_from(4'd0);
    run_from(4'd1);
    // edges through a vertex beyond the count are stored but unused
    set_vertex_count(5'd5);
    write_edge(4'd0, 4'd9, 16'd1);
    write_edge(4'd9, 4'd1, 16'd1);
    write_edge(4'd0, 4'd1, 16'd50);
    run_from(4'd0);
    run_from(4'd7);

    // random phases over several vertex counts
    for (int p = 0; p < PHASES; p++) begin
      set_vertex_count(phase_vcount[p][CFG_W-1:0]);
      n_eff = (phase_vcount[p] == 0) ? 1 :
              (phase_vcount[p] > MAX_VERTICES) ? MAX_VERTICES : phase_vcount[p];
      no_gaps = (p == 7);
      // long receiver hold while runs keep coming in
      if (p == 3) begin
        hold_pending = 1'b1;
        repeat (4) run_from(VTX_W'($urandom_range(0, n_eff - 1)));
      end
      repeat (PHASE_ITEMS) random_item(n_eff);
    end
    no_gaps = 1'b0;

    wait_idle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sssp_pkg.sv
rtl/sssp_ram.sv
rtl/sssp_alu.sv
rtl/single_source_shortest_path_unit.sv
tb/sssp_distance_checker.sv
tb/tb_top.sv
